### hw/rtl/lse_pkg.sv
// ----------------------------------------------------------------------------
// LIFO stack engine package
// Command and status codes, sequencer states and the response stage record.
// ----------------------------------------------------------------------------
package lse_pkg;

   typedef enum logic [2:0] {
      CMD_PUSH        = 3'd0,
      CMD_POP         = 3'd1,
      CMD_PEEK        = 3'd2,
      CMD_DUMP_TOP    = 3'd3,
      CMD_DUMP_BOTTOM = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_DUMP = 1'b1
   } state_type;

   typedef struct packed {
      logic       use_ram;
      status_type status;
      logic       is_empty;
      logic       last;
   } rsp_meta_type;

   localparam int unsigned ValueWidth = 32;
   localparam int unsigned ReqWidth   = 40;
   localparam int unsigned RspWidth   = 40;

endpackage

### hw/rtl/lifo_stack_engine.sv
// A result passes through the pending stage and then the response register before it appears on rsp.
// Push, pop and peek are accepted whenever the pending stage is free; a dump of a non-empty
// stack holds off the input until every entry is read, one RAM read per entry.
// The single read port of the entry RAM and back-pressure on rsp set the dump rate.
// Reset clears the entry count and all valid flags; the entry RAM is not
// cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// LIFO stack engine
// Fixed-depth stack of 32-bit words with push, pop, peek and dump commands.
// ----------------------------------------------------------------------------
module lifo_stack_engine
   import lse_pkg::*;
#(
   parameter int unsigned DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // [2:0] command, [34:3] push_value, [39:35] zero
   input  logic [ReqWidth-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // [31:0] value, [33:32] status, [34] is_empty, [39:35] zero
   output logic [RspWidth-1:0] rsp_tdata,
   output logic                rsp_tlast
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          idx_ff, idx_in;
   logic [AW-1:0]          left_ff, left_in;
   logic                   dir_top_ff, dir_top_in;

   logic                   pend_valid_ff, pend_valid_in;
   rsp_meta_type           pend_meta_ff, pend_meta_in;

   logic                   rsp_valid_ff;
   logic [ValueWidth-1:0]  rsp_value_ff;
   rsp_meta_type           rsp_meta_ff;

   logic                   out_free;
   logic                   pend_free;
   logic                   req_fire;
   cmd_type                req_cmd;
   logic [ValueWidth-1:0]  req_value;
   logic [CW-1:0]          count_dec;
   logic                   stack_empty;
   logic                   stack_full;

   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_rd_addr;
   logic [ValueWidth-1:0]  ram_rd_data;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign pend_free   = !pend_valid_ff || out_free;
   assign req_fire    = req_tvalid && req_tready;
   assign req_cmd     = cmd_type'(req_tdata[2:0]);
   assign req_value   = req_tdata[34:3];
   assign count_dec   = count_ff - CW'(1);
   assign stack_empty = (count_ff == '0);
   assign stack_full  = (count_ff == CW'(DEPTH));

   lse_ram #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (ValueWidth)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         if (pend_valid_ff && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      left_ff      <= left_in;
      dir_top_ff   <= dir_top_in;
      pend_meta_ff <= pend_meta_in;
      if (pend_valid_ff && out_free) begin
         rsp_meta_ff  <= pend_meta_ff;
         rsp_value_ff <= pend_meta_ff.use_ram ? ram_rd_data : '0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      left_in       = left_ff;
      dir_top_in    = dir_top_ff;
      pend_valid_in = pend_free ? 1'b0 : pend_valid_ff;
      pend_meta_in  = pend_meta_ff;
      req_tready    = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = count_ff[AW-1:0];
      ram_rd_en     = 1'b0;
      ram_rd_addr   = count_dec[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            req_tready = pend_free;
            if (req_fire) begin
               pend_meta_in.use_ram  = 1'b0;
               pend_meta_in.status   = ST_OK;
               pend_meta_in.is_empty = stack_empty;
               pend_meta_in.last     = 1'b1;
               case (req_cmd)
                  CMD_PUSH: begin
                     pend_valid_in = 1'b1;
                     if (stack_full) begin
                        pend_meta_in.status = ST_FULL;
                     end else begin
                        ram_wr_en             = 1'b1;
                        count_in              = count_ff + CW'(1);
                        pend_meta_in.is_empty = 1'b0;
                     end
                  end
                  CMD_POP: begin
                     pend_valid_in = 1'b1;
                     if (stack_empty) begin
                        pend_meta_in.status = ST_EMPTY;
                     end else begin
                        ram_rd_en             = 1'b1;
                        count_in              = count_dec;
                        pend_meta_in.use_ram  = 1'b1;
                        pend_meta_in.is_empty = (count_dec == '0);
                     end
                  end
                  CMD_PEEK: begin
                     pend_valid_in = 1'b1;
                     if (stack_empty) begin
                        pend_meta_in.status = ST_EMPTY;
                     end else begin
                        ram_rd_en            = 1'b1;
                        pend_meta_in.use_ram = 1'b1;
                     end
                  end
                  CMD_DUMP_TOP, CMD_DUMP_BOTTOM: begin
                     if (stack_empty) begin
                        pend_valid_in       = 1'b1;
                        pend_meta_in.status = ST_EMPTY;
                     end else begin
                        state_in   = S_DUMP;
                        dir_top_in = (req_cmd == CMD_DUMP_TOP);
                        idx_in     = (req_cmd == CMD_DUMP_TOP) ? count_dec[AW-1:0] : '0;
                        left_in    = count_dec[AW-1:0];
                     end
                  end
                  default: begin
                     pend_valid_in = pend_free ? 1'b0 : pend_valid_ff;
                  end
               endcase
            end
         end
         S_DUMP: begin
            if (pend_free) begin
               ram_rd_en             = 1'b1;
               ram_rd_addr           = idx_ff;
               pend_valid_in         = 1'b1;
               pend_meta_in.use_ram  = 1'b1;
               pend_meta_in.status   = ST_OK;
               pend_meta_in.is_empty = 1'b0;
               pend_meta_in.last     = (left_ff == '0);
               idx_in                = dir_top_ff ? idx_ff - AW'(1) : idx_ff + AW'(1);
               left_in               = left_ff - AW'(1);
               if (left_ff == '0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_meta_ff.last;
   assign rsp_tdata  = {5'd0, rsp_meta_ff.is_empty, rsp_meta_ff.status, rsp_value_ff};

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds depth");

   a_dump_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |-> !req_tready)
      else $error("input accepted during dump");

   a_stall_holds_data: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && pend_meta_ff.use_ram && !out_free)
         |=> (pend_valid_ff && $stable(ram_rd_data)))
      else $error("stalled read data lost");

   a_full_push_refused: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_cmd == CMD_PUSH && stack_full) |=> $stable(count_ff))
      else $error("push onto full stack changed count");
`endif

endmodule

### hw/rtl/lse_ram.sv
// ----------------------------------------------------------------------------
// LIFO stack entry memory
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lse_ram #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6,
   parameter int unsigned DW    = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
